// ===== rtl/rks_pkg.sv =====
// ----------------------------------------------------------------------------
// rks_pkg
// Shared types, widths and constants of the rotation keyframe sampler.
// ----------------------------------------------------------------------------
package rks_pkg;

  // table and field sizes
  localparam int MAX_KEYS     = 64;
  localparam int KEY_IDX_W    = 6;
  localparam int COUNT_W      = 7;
  localparam int COMP_W       = 16;
  localparam int FRAME_W      = 16;
  localparam int IN_TDATA_W   = 104;
  localparam int OUT_TDATA_W  = 64;

  // request queue between front and back
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = 1;

  // arithmetic constants
  localparam int CORDIC_STEPS = 24;
  localparam int CORD_IDX_W   = 5;
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd163008219;
  localparam logic [COMP_W-1:0] Q14_ONE   = 16'h4000;
  localparam int NEAR_LIMIT   = 2684;

  // operation codes on tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // request kinds after classification
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_IDENT  = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [KEY_IDX_W-1:0] slot;
    logic [FRAME_W-1:0]   frame;
    logic [3:0][COMP_W-1:0] quat;   // x in the lowest lane, w in the highest
    logic [COUNT_W-1:0]   n_keys;
  } rks_req_t;

  // arctangent of 2^-i in Q24 radians
  function automatic logic [23:0] atan_q24(input logic [CORD_IDX_W-1:0] idx);
    logic [23:0] v;
    unique case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rks_front.sv =====
// ----------------------------------------------------------------------------
// rks_front
// Accepts input requests, holds key_count and classifies each request.
// ----------------------------------------------------------------------------
module rks_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rks_pkg::COUNT_W-1:0]      cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,
  input  logic [rks_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             q_full,
  output logic                             q_push,
  output rks_pkg::rks_req_t                q_req
);
  import rks_pkg::*;

  logic [COUNT_W-1:0] key_count_r;
  logic [COUNT_W-1:0] n_keys;
  logic [FRAME_W-1:0] smp_frame;

  // key count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_wr_en) begin
      key_count_r <= cfg_wr_data;
    end
  end

  assign n_keys    = (key_count_r > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : key_count_r;
  assign smp_frame = in_tdata[101:86];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // classify: load, identity sample or full sample
  always_comb begin
    q_req.slot   = in_tdata[5:0];
    q_req.quat   = in_tdata[85:22];
    q_req.n_keys = n_keys;
    if (in_tuser == OP_LOAD) begin
      q_req.kind  = KIND_LOAD;
      q_req.frame = in_tdata[21:6];
    end else begin
      q_req.frame = smp_frame;
      if (smp_frame == '0 || n_keys == '0) begin
        q_req.kind = KIND_IDENT;
      end else begin
        q_req.kind = KIND_SAMPLE;
      end
    end
  end

endmodule

// ===== rtl/rks_fifo.sv =====
// ----------------------------------------------------------------------------
// rks_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module rks_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rks_pkg::rks_req_t push_req,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output rks_pkg::rks_req_t head_req
);
  import rks_pkg::*;

  rks_req_t                entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_PTR_W:0]     cnt_r;
  logic                    do_pop;

  assign full     = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid    = (cnt_r != '0);
  assign head_req = entry_r[rd_ptr_r];
  assign do_pop   = pop && valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/rks_back.sv =====
// ----------------------------------------------------------------------------
// rks_back
// Key table and sample engine: search, alpha divide, dot product, square
// root, shared CORDIC, sine-ratio divides and the final blend.
// ----------------------------------------------------------------------------
module rks_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  rks_pkg::rks_req_t                 q_req,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rks_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser
);
  import rks_pkg::*;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SADDR = 5'd1;
  localparam logic [4:0] S_SCHK  = 5'd2;
  localparam logic [4:0] S_ALPHA = 5'd3;
  localparam logic [4:0] S_DIV   = 5'd4;
  localparam logic [4:0] S_RD1   = 5'd5;
  localparam logic [4:0] S_RD2   = 5'd6;
  localparam logic [4:0] S_RD3   = 5'd7;
  localparam logic [4:0] S_DOT   = 5'd8;
  localparam logic [4:0] S_SIGN  = 5'd9;
  localparam logic [4:0] S_SQ    = 5'd10;
  localparam logic [4:0] S_SQRT  = 5'd11;
  localparam logic [4:0] S_CORD  = 5'd12;
  localparam logic [4:0] S_SOCHK = 5'd13;
  localparam logic [4:0] S_ANG   = 5'd14;
  localparam logic [4:0] S_ANGT  = 5'd15;
  localparam logic [4:0] S_MIX   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  // divider jobs
  localparam logic [1:0] DT_ALPHA = 2'd0;
  localparam logic [1:0] DT_S1    = 2'd1;
  localparam logic [1:0] DT_S2    = 2'd2;

  // CORDIC jobs
  localparam logic [1:0] CT_VEC = 2'd0;
  localparam logic [1:0] CT_SO  = 2'd1;
  localparam logic [1:0] CT_SA  = 2'd2;
  localparam logic [1:0] CT_SB  = 2'd3;

  localparam int QUO_W = 60;

  logic [4:0] state_r;

  // key table
  logic [FRAME_W-1:0]     times_mem [MAX_KEYS];
  logic [4*COMP_W-1:0]    rot_mem   [MAX_KEYS];
  logic [FRAME_W-1:0]     rd_time_q;
  logic [4*COMP_W-1:0]    rd_rot_q;
  logic [KEY_IDX_W-1:0]   rd_addr;
  logic                   mem_we;

  // search
  logic [FRAME_W-1:0]     frame_r;
  logic [COUNT_W-1:0]     n_r;
  logic [KEY_IDX_W-1:0]   idx_r, f1_r, f2_r;
  logic [FRAME_W-1:0]     time1_r, time2_r;
  logic                   found_r;
  logic                   k_le, k_ge, k_last;
  logic [FRAME_W-1:0]     t1, t2;

  // divider
  logic [63:0]            dvd_r;
  logic [31:0]            rem_r, dsr_r, rem_nxt;
  logic [QUO_W-1:0]       quo_r, quo_fin;
  logic [5:0]             dcnt_r;
  logic [1:0]             dtag_r;
  logic                   dneg_r;
  logic [32:0]            div_trial;
  logic                   div_ge;
  logic signed [39:0]     div_mag, div_sgn;

  // operands and dot product
  logic [16:0]            alpha_r;
  logic [3:0][COMP_W-1:0] qa_r, qb_r;
  logic [1:0]             cnt_r;
  logic signed [34:0]     dot_r, dot_abs;
  logic signed [31:0]     dot_prod;
  logic                   neg_r;
  logic signed [35:0]     near_diff;
  logic signed [39:0]     s1_r, s2_r, s_lin;

  // square root
  logic [56:0]            sq_n_r;
  logic [57:0]            sq_r_r, sq_bit_r, sq_sum, sq_r_nxt;
  logic                   sq_ge;
  logic [55:0]            cc;

  // CORDIC
  logic signed [31:0]     cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic signed [31:0]     c_dx, c_dy, c_atan;
  logic [CORD_IDX_W-1:0]  ci_r;
  logic                   vec_r, c_u;
  logic [1:0]             ctag_r;
  logic signed [31:0]     omega_r, so_r, sa_r, sb_r;
  logic [31:0]            sa_mag, sb_mag;

  // angle products
  logic signed [49:0]     angp_r, ang_prod, ang_q;
  logic                   angb_r;
  logic [16:0]            ang_fac;

  // blend
  logic [1:0]             mph_r;
  logic signed [57:0]     acc_r;
  logic signed [55:0]     mix_prod;
  logic signed [57:0]     mix_rnd;
  logic signed [29:0]     mix_v;
  logic [COMP_W-1:0]      mix_sat;

  // result
  logic [3:0][COMP_W-1:0] ores_r;
  logic                   oid_r;
  logic                   out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ores_r;
  assign out_tuser  = oid_r;
  assign q_pop      = (state_r == S_IDLE);
  assign mem_we     = (state_r == S_IDLE) && q_valid && (q_req.kind == KIND_LOAD);

  // read address of the table
  always_comb begin
    unique case (state_r)
      S_SADDR: rd_addr = idx_r;
      S_RD1:   rd_addr = f1_r;
      default: rd_addr = f2_r;
    endcase
  end

  // key table memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      times_mem[q_req.slot] <= q_req.frame;
      rot_mem[q_req.slot]   <= q_req.quat;
    end
    rd_time_q <= times_mem[rd_addr];
    rd_rot_q  <= rot_mem[rd_addr];
  end

  // search compare
  assign k_le   = (rd_time_q <= frame_r);
  assign k_ge   = (rd_time_q >= frame_r);
  assign k_last = ({1'b0, idx_r} == n_r - 1'b1);
  assign t1     = (time1_r < frame_r) ? time1_r : frame_r;
  assign t2     = (time2_r > frame_r) ? time2_r : frame_r;

  // restoring divider step
  assign div_trial = {rem_r, dvd_r[63]};
  assign div_ge    = (div_trial >= {1'b0, dsr_r});
  assign rem_nxt   = div_ge ? 32'(div_trial - {1'b0, dsr_r}) : div_trial[31:0];
  assign quo_fin   = {quo_r[QUO_W-2:0], div_ge};
  assign div_mag   = $signed({1'b0, quo_fin[38:0]});
  assign div_sgn   = dneg_r ? -div_mag : div_mag;
  assign sa_mag    = sa_r[31] ? 32'(-sa_r) : sa_r;
  assign sb_mag    = sb_r[31] ? 32'(-sb_r) : sb_r;

  // dot product and linear scales
  assign dot_prod  = $signed(qa_r[cnt_r]) * $signed(qb_r[cnt_r]);
  assign dot_abs   = dot_r[34] ? -dot_r : dot_r;
  assign near_diff = $signed(36'd268435456) - $signed({1'b0, dot_abs});
  assign s_lin     = $signed({11'b0, alpha_r, 12'b0});

  // square root step
  assign cc       = dot_r[27:0] * dot_r[27:0];
  assign sq_sum   = sq_r_r + sq_bit_r;
  assign sq_ge    = ({1'b0, sq_n_r} >= sq_sum);
  assign sq_r_nxt = sq_ge ? (sq_r_r >> 1) + sq_bit_r : (sq_r_r >> 1);

  // CORDIC step, vectoring or rotation
  assign c_dx   = cy_r >>> ci_r;
  assign c_dy   = cx_r >>> ci_r;
  assign c_atan = $signed({8'b0, atan_q24(ci_r)});
  assign c_u    = vec_r ? cy_r[31] : ~cz_r[31];
  assign cx_nxt = c_u ? cx_r - c_dx : cx_r + c_dx;
  assign cy_nxt = c_u ? cy_r + c_dy : cy_r - c_dy;
  assign cz_nxt = c_u ? cz_r - c_atan : cz_r + c_atan;

  // partial angle, truncated toward zero
  assign ang_fac  = angb_r ? alpha_r : 17'(17'd65536 - alpha_r);
  assign ang_prod = 50'($signed({1'b0, ang_fac}) * omega_r);
  assign ang_q    = angp_r[49] ? ((angp_r + 50'sd65535) >>> 16) : (angp_r >>> 16);

  // blend multiply, round and saturate
  assign mix_prod = (mph_r == 2'd0) ? s1_r * $signed(qa_r[cnt_r])
                                    : s2_r * $signed(qb_r[cnt_r]);
  assign mix_rnd  = acc_r + 58'sd134217728;
  assign mix_v    = mix_rnd[57:28];
  always_comb begin
    priority if (mix_v > 30'sd32767)       mix_sat = 16'h7FFF;
    else if (mix_v < -30'sd32768)          mix_sat = 16'h8000;
    else                                   mix_sat = mix_v[15:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_req.kind)
              KIND_IDENT: begin
                ores_r      <= {Q14_ONE, 48'b0};
                oid_r       <= 1'b1;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
              KIND_SAMPLE: begin
                frame_r <= q_req.frame;
                n_r     <= q_req.n_keys;
                idx_r   <= '0;
                found_r <= 1'b0;
                state_r <= S_SADDR;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_SADDR: state_r <= S_SCHK;
        S_SCHK: begin
          if (k_le || (k_ge && !found_r)) begin
            f1_r    <= idx_r;
            time1_r <= rd_time_q;
            found_r <= 1'b1;
          end
          if (k_ge || k_last) begin
            f2_r    <= idx_r;
            time2_r <= rd_time_q;
            state_r <= S_ALPHA;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SADDR;
          end
        end
        S_ALPHA: begin
          if (t1 == t2) begin
            alpha_r <= '0;
            state_r <= S_RD1;
          end else begin
            dvd_r   <= {16'(frame_r - t1), 48'b0};
            dsr_r   <= {16'b0, 16'(t2 - t1)};
            rem_r   <= '0;
            quo_r   <= '0;
            dcnt_r  <= 6'd31;
            dtag_r  <= DT_ALPHA;
            dneg_r  <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_r == '0) begin
            unique case (dtag_r)
              DT_ALPHA: begin
                alpha_r <= quo_fin[16:0];
                state_r <= S_RD1;
              end
              DT_S1: begin
                // first scale done, start the second
                s1_r   <= div_sgn;
                dvd_r  <= {sb_mag, 32'b0};
                rem_r  <= '0;
                quo_r  <= '0;
                dcnt_r <= 6'(QUO_W - 1);
                dneg_r <= sb_r[31] ^ neg_r;
                dtag_r <= DT_S2;
              end
              default: begin
                s2_r    <= div_sgn;
                cnt_r   <= '0;
                mph_r   <= '0;
                state_r <= S_MIX;
              end
            endcase
          end else begin
            rem_r  <= rem_nxt;
            dvd_r  <= {dvd_r[62:0], 1'b0};
            quo_r  <= quo_fin;
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          qa_r    <= rd_rot_q;
          state_r <= S_RD3;
        end
        S_RD3: begin
          qb_r    <= rd_rot_q;
          dot_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DOT;
        end
        S_DOT: begin
          dot_r <= dot_r + 35'(dot_prod);
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd3) state_r <= S_SIGN;
        end
        S_SIGN: begin
          // fold the shorter arc and preset the linear scales
          dot_r <= dot_abs;
          neg_r <= dot_r[34];
          s1_r  <= 40'sd268435456 - s_lin;
          s2_r  <= dot_r[34] ? -s_lin : s_lin;
          if (near_diff > 36'(NEAR_LIMIT)) begin
            state_r <= S_SQ;
          end else begin
            cnt_r   <= '0;
            mph_r   <= '0;
            state_r <= S_MIX;
          end
        end
        S_SQ: begin
          sq_n_r   <= {1'b1, 56'b0} - {1'b0, cc};
          sq_r_r   <= '0;
          sq_bit_r <= 58'(58'd1 << 56);
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) sq_n_r <= sq_n_r - sq_sum[56:0];
          sq_r_r   <= sq_r_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            cx_r    <= dot_r[31:0];
            cy_r    <= $signed(sq_r_nxt[31:0]);
            cz_r    <= '0;
            ci_r    <= '0;
            vec_r   <= 1'b1;
            ctag_r  <= CT_VEC;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (ci_r == CORD_IDX_W'(CORDIC_STEPS - 1)) begin
            unique case (ctag_r)
              CT_VEC: begin
                omega_r <= cz_nxt;
                cx_r    <= $signed(CORDIC_GAIN_INV);
                cy_r    <= '0;
                cz_r    <= cz_nxt;
                ci_r    <= '0;
                vec_r   <= 1'b0;
                ctag_r  <= CT_SO;
              end
              CT_SO: begin
                so_r    <= cy_nxt;
                state_r <= S_SOCHK;
              end
              CT_SA: begin
                sa_r    <= cy_nxt;
                angb_r  <= 1'b1;
                state_r <= S_ANG;
              end
              default: begin
                sb_r    <= cy_nxt;
                dvd_r   <= {sa_mag, 32'b0};
                dsr_r   <= so_r;
                rem_r   <= '0;
                quo_r   <= '0;
                dcnt_r  <= 6'(QUO_W - 1);
                dneg_r  <= sa_r[31];
                dtag_r  <= DT_S1;
                state_r <= S_DIV;
              end
            endcase
          end else begin
            cx_r <= cx_nxt;
            cy_r <= cy_nxt;
            cz_r <= cz_nxt;
            ci_r <= ci_r + 1'b1;
          end
        end
        S_SOCHK: begin
          if (so_r > 32'sd0) begin
            angb_r  <= 1'b0;
            state_r <= S_ANG;
          end else begin
            cnt_r   <= '0;
            mph_r   <= '0;
            state_r <= S_MIX;
          end
        end
        S_ANG: begin
          angp_r  <= ang_prod;
          state_r <= S_ANGT;
        end
        S_ANGT: begin
          cx_r    <= $signed(CORDIC_GAIN_INV);
          cy_r    <= '0;
          cz_r    <= ang_q[31:0];
          ci_r    <= '0;
          vec_r   <= 1'b0;
          ctag_r  <= angb_r ? CT_SB : CT_SA;
          state_r <= S_CORD;
        end
        S_MIX: begin
          unique case (mph_r)
            2'd0: begin
              acc_r <= 58'(mix_prod);
              mph_r <= 2'd1;
            end
            2'd1: begin
              acc_r <= acc_r + 58'(mix_prod);
              mph_r <= 2'd2;
            end
            default: begin
              ores_r[cnt_r] <= mix_sat;
              mph_r         <= 2'd0;
              cnt_r         <= cnt_r + 1'b1;
              if (cnt_r == 2'd3) begin
                oid_r       <= 1'b0;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
            end
          endcase
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rotation_keyframe_slerp_sampler.sv =====
// ----------------------------------------------------------------------------
// rotation_keyframe_slerp_sampler
// Keyframe rotation table with fixed-point quaternion slerp sampling.
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one key into the table of the back unit;
// a sample request (tuser 1) returns one quaternion. Frame zero or an
// empty table returns identity without a table scan. A sample scans the
// keys one at a time through the single table read port, an address state
// and a check state per key, then runs a bit-serial alpha divide unless
// the clamped times are equal, a serial dot product and a serial blend;
// that is a linear blend. A full slerp adds a square root, four 24-step
// CORDIC runs and two sine-ratio divides on the bit-serial divider and
// CORDIC of the back unit. A two-entry queue lets requests be taken while
// the back unit is busy or a result waits on the output. The user must
// write key_count only while the block is idle; the block itself does not
// enforce this.
module rotation_keyframe_slerp_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rks_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: key_slot, key_frame, key_x, key_y, key_z, key_w, sample_frame, pad
  input  logic [rks_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: out_x, out_y, out_z, out_w
  output logic [rks_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tuser: used_identity
  output logic                              out_tuser
);
  import rks_pkg::*;

  rks_req_t push_req, head_req;
  logic     q_push, q_full, q_valid, q_pop;

  // request intake and classification
  rks_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_req       (push_req)
  );

  // request queue
  rks_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_req (head_req)
  );

  // execution
  rks_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (head_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/rks_checker.sv =====
// ----------------------------------------------------------------------------
// rks_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module rks_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rks_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tuser
);
  import rks_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // identity results carry exactly (0, 0, 0, 1.0)
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == {Q14_ONE, 48'b0})
    else $error("identity result has wrong value");

  // no result is offered right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rotation_keyframe_slerp_sampler rks_checker u_rks_checker (.*);
